FILE: src/lntf_pkg.sv
package lntf_pkg;

   // Largest number of digits one transaction shows; larger counts saturate.
   localparam int MAX_DIGITS = 16;

   // Digit store indexing and the saturated digit count.
   localparam int DIG_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
   localparam int CMP_W     = 6;

   // Field widths of the request and response channels.
   localparam int FUNC_W   = 2;
   localparam int LINE_W   = 2;
   localparam int COLUMN_W = 6;
   localparam int VALUE_W  = 16;
   localparam int DCOUNT_W = 5;
   localparam int BYTE_W   = 8;

   // Display controller bytes.
   localparam logic [BYTE_W-1:0] CMD_SET_CURSOR = 8'h80;
   localparam logic [BYTE_W-1:0] LINE2_OFFSET   = 8'h40;
   localparam logic [BYTE_W-1:0] CHAR_ZERO      = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_PLUS      = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_MINUS     = 8'h2D;

   // Reciprocal of ten: x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for 16-bit x.
   localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
   localparam int          DIV10_SHIFT = 19;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_UDEC = 2'd0,
      FUNC_SDEC = 2'd1,
      FUNC_HEX  = 2'd2,
      FUNC_BIN  = 2'd3
   } func_type;

   localparam logic [LINE_W-1:0] LINE_ONE = 2'd1;
   localparam logic [LINE_W-1:0] LINE_TWO = 2'd2;

   typedef enum logic [1:0] {
      EMIT_CURSOR = 2'd0,
      EMIT_SIGN   = 2'd1,
      EMIT_DIGIT  = 2'd2
   } emit_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_CONV   = 3'd1,
      ST_CURSOR = 3'd2,
      ST_SIGN   = 3'd3,
      ST_DIGIT  = 3'd4
   } state_type;

   typedef struct packed {
      logic     load;
      logic     conv_step;
      logic     out_load;
      emit_type emit_sel;
   } cmd_type;

   typedef struct packed {
      logic has_cursor;
      logic is_signed;
      logic cnt_zero;
      logic conv_done;
      logic last_digit;
      logic out_free;
   } status_type;

endpackage

FILE: src/lntf_datapath.sv
module lntf_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [31:0]                    req_tdata,
   input  lntf_pkg::cmd_type              cmd,
   output lntf_pkg::status_type           status,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,
   output logic                           rsp_tlast,
   output logic                           rsp_tuser
);

   // Unpacked request fields.
   logic [lntf_pkg::FUNC_W-1:0]   req_func;
   logic [lntf_pkg::LINE_W-1:0]   req_line;
   logic [lntf_pkg::COLUMN_W-1:0] req_column;
   logic [lntf_pkg::VALUE_W-1:0]  req_value;
   logic [lntf_pkg::DCOUNT_W-1:0] req_digit_count;

   assign req_func        = req_tdata[1:0];
   assign req_line        = req_tdata[3:2];
   assign req_column      = req_tdata[9:4];
   assign req_value       = req_tdata[25:10];
   assign req_digit_count = req_tdata[30:26];

   // Held request.
   lntf_pkg::func_type               func_ff, func_in;
   logic [lntf_pkg::LINE_W-1:0]      line_ff, line_in;
   logic [lntf_pkg::COLUMN_W-1:0]    column_ff, column_in;
   logic [lntf_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                             neg_ff, neg_in;
   logic [lntf_pkg::VALUE_W-1:0]     work_ff, work_in;
   logic [lntf_pkg::CNT_W-1:0]       idx_ff, idx_in;
   logic [3:0]                       digit_ff [lntf_pkg::MAX_DIGITS];

   // Output register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [lntf_pkg::BYTE_W-1:0]      rsp_byte_ff, rsp_byte_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic                             rsp_is_data_ff, rsp_is_data_in;

   logic [lntf_pkg::CMP_W-1:0]       dc_ext;
   logic [lntf_pkg::VALUE_W-1:0]     mag;
   logic [31:0]                      prod;
   logic [lntf_pkg::VALUE_W-1:0]     quot;
   logic [lntf_pkg::VALUE_W-1:0]     quot10;
   logic [lntf_pkg::VALUE_W-1:0]     rem_full;
   logic [3:0]                       rem;
   logic [lntf_pkg::CNT_W-1:0]       idx_dec;
   logic [3:0]                       emit_digit;
   logic [lntf_pkg::BYTE_W-1:0]      digit_char;
   logic [lntf_pkg::BYTE_W-1:0]      cursor_pos;
   logic                             out_free;

   // One digit per step, least significant first.
   always_comb begin
      prod     = 32'(work_ff) * 32'(lntf_pkg::DIV10_MUL);
      quot     = 16'(prod >> lntf_pkg::DIV10_SHIFT);
      quot10   = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
      rem_full = work_ff - quot10;
      rem      = rem_full[3:0];
      case (func_ff)
         lntf_pkg::FUNC_HEX: begin
            quot = {4'b0000, work_ff[15:4]};
            rem  = work_ff[3:0];
         end
         lntf_pkg::FUNC_BIN: begin
            quot = {1'b0, work_ff[15:1]};
            rem  = {3'b000, work_ff[0]};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      dc_ext     = lntf_pkg::CMP_W'(req_digit_count);
      mag        = req_value[15] ? 16'(~req_value + 16'd1) : req_value;
      idx_dec    = idx_ff - lntf_pkg::CNT_W'(1);
      emit_digit = digit_ff[idx_dec[lntf_pkg::DIG_IDX_W-1:0]];
      if (emit_digit < 4'd10) begin
         digit_char = lntf_pkg::CHAR_ZERO + {4'b0000, emit_digit};
      end else begin
         digit_char = lntf_pkg::CHAR_UPPER_A + {4'b0000, emit_digit} - 8'd10;
      end
      cursor_pos = 8'(column_ff) + 8'hFF;
      if (line_ff == lntf_pkg::LINE_TWO) begin
         cursor_pos = cursor_pos + lntf_pkg::LINE2_OFFSET;
      end
      out_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      func_in   = func_ff;
      line_in   = line_ff;
      column_in = column_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      work_in   = work_ff;
      idx_in    = idx_ff;
      if (cmd.load) begin
         func_in   = lntf_pkg::func_type'(req_func);
         line_in   = req_line;
         column_in = req_column;
         if (dc_ext > lntf_pkg::CMP_W'(lntf_pkg::MAX_DIGITS)) begin
            cnt_in = lntf_pkg::CNT_W'(lntf_pkg::MAX_DIGITS);
         end else begin
            cnt_in = lntf_pkg::CNT_W'(dc_ext);
         end
         neg_in  = req_value[15];
         work_in = (lntf_pkg::func_type'(req_func) == lntf_pkg::FUNC_SDEC) ? mag : req_value;
         idx_in  = '0;
      end else if (cmd.conv_step) begin
         work_in = quot;
         idx_in  = idx_ff + lntf_pkg::CNT_W'(1);
      end else if (cmd.out_load && cmd.emit_sel == lntf_pkg::EMIT_DIGIT) begin
         idx_in = idx_dec;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_byte_in    = rsp_byte_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_is_data_in = rsp_is_data_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         case (cmd.emit_sel)
            lntf_pkg::EMIT_CURSOR: begin
               rsp_byte_in    = lntf_pkg::CMD_SET_CURSOR | cursor_pos;
               rsp_is_data_in = 1'b0;
               rsp_last_in    = (func_ff != lntf_pkg::FUNC_SDEC) && (cnt_ff == '0);
            end
            lntf_pkg::EMIT_SIGN: begin
               rsp_byte_in    = neg_ff ? lntf_pkg::CHAR_MINUS : lntf_pkg::CHAR_PLUS;
               rsp_is_data_in = 1'b1;
               rsp_last_in    = (cnt_ff == '0);
            end
            default: begin
               rsp_byte_in    = digit_char;
               rsp_is_data_in = 1'b1;
               rsp_last_in    = (idx_ff == lntf_pkg::CNT_W'(1));
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      line_ff        <= line_in;
      column_ff      <= column_in;
      cnt_ff         <= cnt_in;
      neg_ff         <= neg_in;
      work_ff        <= work_in;
      idx_ff         <= idx_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_is_data_ff <= rsp_is_data_in;
      if (cmd.conv_step) begin
         digit_ff[idx_ff[lntf_pkg::DIG_IDX_W-1:0]] <= rem;
      end
   end

   assign status.has_cursor = (line_ff == lntf_pkg::LINE_ONE) || (line_ff == lntf_pkg::LINE_TWO);
   assign status.is_signed  = (func_ff == lntf_pkg::FUNC_SDEC);
   assign status.cnt_zero   = (cnt_ff == '0);
   assign status.conv_done  = (idx_ff == cnt_ff);
   assign status.last_digit = (idx_ff == lntf_pkg::CNT_W'(1));
   assign status.out_free   = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_is_data_ff;

endmodule

FILE: src/lntf_ctrl.sv
module lntf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  lntf_pkg::status_type   status,
   output lntf_pkg::cmd_type      cmd
);

   lntf_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lntf_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = lntf_pkg::ST_CONV;
            end
         end
         lntf_pkg::ST_CONV: begin
            if (status.conv_done) begin
               if (status.has_cursor) begin
                  state_in = lntf_pkg::ST_CURSOR;
               end else if (status.is_signed) begin
                  state_in = lntf_pkg::ST_SIGN;
               end else if (!status.cnt_zero) begin
                  state_in = lntf_pkg::ST_DIGIT;
               end else begin
                  state_in = lntf_pkg::ST_IDLE;
               end
            end
         end
         lntf_pkg::ST_CURSOR: begin
            if (status.out_free) begin
               if (status.is_signed) begin
                  state_in = lntf_pkg::ST_SIGN;
               end else if (!status.cnt_zero) begin
                  state_in = lntf_pkg::ST_DIGIT;
               end else begin
                  state_in = lntf_pkg::ST_IDLE;
               end
            end
         end
         lntf_pkg::ST_SIGN: begin
            if (status.out_free) begin
               state_in = status.cnt_zero ? lntf_pkg::ST_IDLE : lntf_pkg::ST_DIGIT;
            end
         end
         lntf_pkg::ST_DIGIT: begin
            if (status.out_free && status.last_digit) begin
               state_in = lntf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lntf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      cmd.load      = 1'b0;
      cmd.conv_step = 1'b0;
      cmd.out_load  = 1'b0;
      cmd.emit_sel  = lntf_pkg::EMIT_DIGIT;
      case (state_ff)
         lntf_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         lntf_pkg::ST_CONV: begin
            cmd.conv_step = !status.conv_done;
         end
         lntf_pkg::ST_CURSOR: begin
            cmd.out_load = status.out_free;
            cmd.emit_sel = lntf_pkg::EMIT_CURSOR;
         end
         lntf_pkg::ST_SIGN: begin
            cmd.out_load = status.out_free;
            cmd.emit_sel = lntf_pkg::EMIT_SIGN;
         end
         lntf_pkg::ST_DIGIT: begin
            cmd.out_load = status.out_free;
            cmd.emit_sel = lntf_pkg::EMIT_DIGIT;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lntf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/lcd_number_text_formatter_top.sv
// Formats one 16-bit number per request transaction as the byte stream a
// character LCD controller expects: a set-cursor command (only for line 1 or
// 2), a '+' or '-' for signed decimal, then digit_count digits (saturated to
// 16), most significant first, in unsigned decimal, signed decimal, upper-case
// hex or binary. Each response transaction carries one byte in rsp_tdata,
// rsp_tuser high for character data and low for a command, and rsp_tlast on
// the final byte. A request with nothing to show produces no response at all.
// One request is in flight at a time: after acceptance the digit extractor
// works out the requested digits one per step, then each byte leaves through
// the output register at most once a cycle, as the sink allows. The next
// request is accepted while the final byte still waits.
module lcd_number_text_formatter_top (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // func[1:0], line[3:2], column[9:4],
                                    // value[25:10], digit_count[30:26], zero[31]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte[7:0]
   output logic        rsp_tlast,   // last byte of the request
   output logic        rsp_tuser    // is_data[0]
);

   lntf_pkg::cmd_type    cmd;
   lntf_pkg::status_type status;

   // Sequence the cursor, sign and digit bytes.
   lntf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Hold the request, extract digits, drive the output register.
   lntf_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the LCD number formatter.
// A short table of directed requests runs first; some rows carry their byte
// sequence typed in, the rest go through the formatter model below. Random
// requests follow, mostly well-formed with random content plus some
// out-of-range columns and digit counts. Both sides insert random idle
// bursts except in the closing stretch.
module tb;

   localparam int N_DIRECTED     = 20;
   localparam int N_RANDOM       = 300;   // requests that emit at least one byte
   localparam int CALM_AFTER     = 250;   // drop idling from here on
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
   localparam int DRAIN_CYCLES   = 50;

   // One request, plus an optional literal expectation:
   // an optional command byte and up to eight characters, first char highest.
   typedef struct packed {
      lntf_pkg::func_type fn;
      logic [1:0]         ln;
      logic [5:0]         col;
      logic [15:0]        val;
      logic [4:0]         cnt;
      logic               typed;
      logic               has_cmd;
      logic [7:0]         cmd;
      logic [3:0]         text_len;
      logic [63:0]        text;
   } stim_row_type;

   // One byte on the way to the display controller.
   typedef struct packed {
      logic       is_data;
      logic [7:0] code;
      logic       last;
   } lcd_byte_type;

   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      // smallest number, off-screen line, one digit
      '{lntf_pkg::FUNC_UDEC, 2'd0, 6'd1,  16'h0000, 5'd1,  1'b1, 1'b0, 8'h00, 4'd1, "0"},
      // largest unsigned value at home position
      '{lntf_pkg::FUNC_UDEC, 2'd1, 6'd1,  16'hFFFF, 5'd5,  1'b1, 1'b1, 8'h80, 4'd5, "65535"},
      // cursor only, line two, last legal column
      '{lntf_pkg::FUNC_UDEC, 2'd2, 6'd40, 16'hFFFF, 5'd0,  1'b1, 1'b1, 8'hE7, 4'd0, ""},
      // column zero wraps on both lines
      '{lntf_pkg::FUNC_UDEC, 2'd1, 6'd0,  16'h0000, 5'd0,  1'b1, 1'b1, 8'hFF, 4'd0, ""},
      '{lntf_pkg::FUNC_UDEC, 2'd2, 6'd0,  16'h0000, 5'd0,  1'b1, 1'b1, 8'hBF, 4'd0, ""},
      // nothing to emit: line three and line zero, no sign, no digits
      '{lntf_pkg::FUNC_UDEC, 2'd3, 6'd63, 16'h1234, 5'd0,  1'b1, 1'b0, 8'h00, 4'd0, ""},
      '{lntf_pkg::FUNC_HEX,  2'd0, 6'd5,  16'hFFFF, 5'd0,  1'b1, 1'b0, 8'h00, 4'd0, ""},
      // signed extremes; the most negative value shows its full magnitude
      '{lntf_pkg::FUNC_SDEC, 2'd0, 6'd1,  16'h8000, 5'd5,  1'b1, 1'b0, 8'h00, 4'd6, "-32768"},
      '{lntf_pkg::FUNC_SDEC, 2'd0, 6'd1,  16'h7FFF, 5'd5,  1'b1, 1'b0, 8'h00, 4'd6, "+32767"},
      '{lntf_pkg::FUNC_SDEC, 2'd3, 6'd1,  16'hFFFF, 5'd1,  1'b1, 1'b0, 8'h00, 4'd2, "-1"},
      // sign only carries the last flag
      '{lntf_pkg::FUNC_SDEC, 2'd0, 6'd1,  16'h0000, 5'd0,  1'b1, 1'b0, 8'h00, 4'd1, "+"},
      '{lntf_pkg::FUNC_HEX,  2'd0, 6'd1,  16'hABCD, 5'd4,  1'b1, 1'b0, 8'h00, 4'd4, "ABCD"},
      // leading positions above the number give zeros
      '{lntf_pkg::FUNC_HEX,  2'd0, 6'd1,  16'hFFFF, 5'd8,  1'b1, 1'b0, 8'h00, 4'd8,
        "0000FFFF"},
      '{lntf_pkg::FUNC_BIN,  2'd0, 6'd1,  16'h0005, 5'd3,  1'b1, 1'b0, 8'h00, 4'd3, "101"},
      '{lntf_pkg::FUNC_HEX,  2'd3, 6'd1,  16'h0000, 5'd1,  1'b1, 1'b0, 8'h00, 4'd1, "0"},
      // long runs and saturated digit counts go through the model
      '{lntf_pkg::FUNC_BIN,  2'd2, 6'd33, 16'h8001, 5'd16, 1'b0, 1'b0, 8'h00, 4'd0, ""},
      '{lntf_pkg::FUNC_UDEC, 2'd1, 6'd63, 16'd12345, 5'd31, 1'b0, 1'b0, 8'h00, 4'd0, ""},
      '{lntf_pkg::FUNC_HEX,  2'd2, 6'd20, 16'h1234, 5'd17, 1'b0, 1'b0, 8'h00, 4'd0, ""},
      '{lntf_pkg::FUNC_SDEC, 2'd3, 6'd1,  16'h8000, 5'd16, 1'b0, 1'b0, 8'h00, 4'd0, ""},
      '{lntf_pkg::FUNC_UDEC, 2'd1, 6'd16, 16'hFFFF, 5'd16, 1'b0, 1'b0, 8'h00, 4'd0, ""}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // func[1:0], line[3:2], column[9:4],
                                  // value[25:10], digit_count[30:26], zero[31]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // out_byte[7:0]
   logic        rsp_tlast;
   logic        rsp_tuser;        // is_data[0]

   lcd_byte_type pending_bytes[$];   // bytes the display should see, oldest first
   int           mismatches = 0;
   int           idle_cycles = 0;
   int           stall_left = 0;
   bit           calm = 1'b0;        // no idling on either side once set

   lcd_number_text_formatter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // Queue a finished sequence, flagging its final byte.
   function automatic void queue_sequence(lcd_byte_type seq [lntf_pkg::MAX_DIGITS+2],
                                          int n);
      for (int k = 0; k < n; k++) begin
         seq[k].last = (k == n - 1);
         pending_bytes.push_back(seq[k]);
      end
   endfunction

   // Work out the bytes one request produces; return how many.
   function automatic int format_number(stim_row_type row);
      lcd_byte_type seq [lntf_pkg::MAX_DIGITS+2];
      logic [3:0]   digit [lntf_pkg::MAX_DIGITS];
      logic [7:0]   pos;
      logic [16:0]  mag;
      int unsigned  radix;
      int           n_digits;
      int           n;
      n = 0;
      n_digits = (row.cnt > lntf_pkg::MAX_DIGITS) ? lntf_pkg::MAX_DIGITS : int'(row.cnt);
      if (row.ln == lntf_pkg::LINE_ONE || row.ln == lntf_pkg::LINE_TWO) begin
         // column is one-based; zero wraps to the top of the byte
         pos = {2'b00, row.col} - 8'd1;
         if (row.ln == lntf_pkg::LINE_TWO)
            pos = pos + lntf_pkg::LINE2_OFFSET;
         seq[n] = '{1'b0, lntf_pkg::CMD_SET_CURSOR | pos, 1'b0};
         n++;
      end
      mag = {1'b0, row.val};
      if (row.fn == lntf_pkg::FUNC_SDEC) begin
         if (row.val[15]) begin
            seq[n] = '{1'b1, lntf_pkg::CHAR_MINUS, 1'b0};
            mag = 17'h10000 - mag;
         end else begin
            seq[n] = '{1'b1, lntf_pkg::CHAR_PLUS, 1'b0};
         end
         n++;
      end
      radix = (row.fn == lntf_pkg::FUNC_HEX) ? 16 : (row.fn == lntf_pkg::FUNC_BIN) ? 2 : 10;
      for (int i = 0; i < lntf_pkg::MAX_DIGITS; i++) begin
         digit[i] = 4'(mag % radix);
         mag = 17'(mag / radix);
      end
      for (int i = n_digits; i > 0; i--) begin
         seq[n].is_data = 1'b1;
         seq[n].code = (digit[i-1] < 4'd10)
                       ? lntf_pkg::CHAR_ZERO + 8'(digit[i-1])
                       : lntf_pkg::CHAR_UPPER_A + 8'(digit[i-1]) - 8'd10;
         seq[n].last = 1'b0;
         n++;
      end
      queue_sequence(seq, n);
      return n;
   endfunction

   // Queue the sequence typed into a directed row; return how many bytes.
   function automatic int queue_literal(stim_row_type row);
      lcd_byte_type seq [lntf_pkg::MAX_DIGITS+2];
      int           n;
      n = 0;
      if (row.has_cmd) begin
         seq[n] = '{1'b0, row.cmd, 1'b0};
         n++;
      end
      for (int j = 0; j < int'(row.text_len); j++) begin
         seq[n] = '{1'b1, row.text[8*(int'(row.text_len)-1-j) +: 8], 1'b0};
         n++;
      end
      queue_sequence(seq, n);
      return n;
   endfunction

   // Offer one request, hold it until accepted, then record what it should emit.
   task automatic send_request(input stim_row_type row, output int n_emitted);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 15);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, row.cnt, row.val, row.col, row.ln, row.fn};
      do @(posedge clock); while (!req_tready);
      if (row.typed) begin
         n_emitted = queue_literal(row);
      end else begin
         n_emitted = format_number(row);
      end
   endtask

   // Random request: mostly on-screen columns and short digit counts,
   // with a share of extreme values and out-of-range fields.
   function automatic stim_row_type random_request();
      stim_row_type row;
      row = '0;
      row.fn  = lntf_pkg::func_type'($urandom_range(0, 3));
      row.ln  = 2'($urandom_range(0, 3));
      row.col = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(1, 40));
      case ($urandom_range(0, 9))
         0:       row.val = 16'h0000;
         1:       row.val = 16'hFFFF;
         2:       row.val = 16'h8000;
         3:       row.val = 16'h7FFF;
         default: row.val = 16'($urandom_range(0, 65535));
      endcase
      row.cnt = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(0, 6));
      return row;
   endfunction

   // Response side: check each transaction, then pick the next ready level.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            $error("unexpected byte 0x%02h (tuser %0b tlast %0b)",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            mismatches++;
         end else begin
            if (rsp_tuser !== pending_bytes[0].is_data) begin
               $error("is_data: expected %0b, got %0b", pending_bytes[0].is_data, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata !== pending_bytes[0].code) begin
               $error("out_byte: expected 0x%02h, got 0x%02h",
                      pending_bytes[0].code, rsp_tdata);
               mismatches++;
            end
            if (rsp_tlast !== pending_bytes[0].last) begin
               $error("last: expected %0b, got %0b", pending_bytes[0].last, rsp_tlast);
               mismatches++;
            end
            void'(pending_bytes.pop_front());
         end
      end
      // Start a stall burst only after a ready cycle so bursts never chain.
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && rsp_tready && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("lcd_number_text_formatter_top verification failed");
         $finish;
      end
   end

   initial begin
      int emitted;
      int n_out;
      emitted = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIRECTED; r++)
         send_request(DIRECTED[r], n_out);

      // Count only requests that produce bytes; silent ones are extra noise.
      while (emitted < N_RANDOM) begin
         calm = (emitted >= CALM_AFTER);
         send_request(random_request(), n_out);
         if (n_out > 0)
            emitted++;
      end
      req_tvalid <= 1'b0;

      // Drain, then give stray bytes a chance to show up.
      while (pending_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("lcd_number_text_formatter_top verification clean");
      else
         $display("lcd_number_text_formatter_top verification failed");
      $finish;
   end

endmodule
